>>> rtl/chsp_pkg.sv
`default_nettype none
package chsp_pkg;
   localparam int unsigned DefMaxVertices = 64;
   localparam int unsigned DefFracBits = 16;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned SizeWidth = 31;
   localparam int unsigned CountWidth = 7;
   localparam int unsigned ProdWidth = 2 * ValueWidth;
   localparam int unsigned AccWidth = ProdWidth + 2;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_LOAD   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROT,
      ST_SCAN,
      ST_FETCH,
      ST_XFORM,
      ST_DONE
   } state_type;

   // multiply-accumulate control from sequencer to datapath
   typedef struct packed {
      logic       clear;
      logic       accumulate;
   } mac_ctrl_type;

   function automatic logic signed [ValueWidth-1:0] sat32(
      input logic signed [AccWidth-1:0] x
   );
      logic signed [AccWidth-1:0] hi;
      logic signed [AccWidth-1:0] lo;
      begin
         hi = AccWidth'($signed({1'b0, {(ValueWidth-1){1'b1}}}));
         lo = -hi - AccWidth'(1);
         if (x > hi) sat32 = {1'b0, {(ValueWidth-1){1'b1}}};
         else if (x < lo) sat32 = {1'b1, {(ValueWidth-1){1'b0}}};
         else sat32 = x[ValueWidth-1:0];
      end
   endfunction
endpackage
`default_nettype wire

>>> rtl/chsp_req_if.sv
`default_nettype none
interface chsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  row;
   logic signed [31:0] value_x;
   logic signed [31:0] value_y;
   logic signed [31:0] value_z;
   logic signed [31:0] value_w;
   modport source(output valid, kind, row, value_x, value_y, value_z, value_w, input ready);
   modport sink(input valid, kind, row, value_x, value_y, value_z, value_w, output ready);
endinterface
`default_nettype wire

>>> rtl/chsp_rsp_if.sv
`default_nettype none
interface chsp_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] support_x;
   logic signed [31:0] support_y;
   logic signed [31:0] support_z;
   logic signed [31:0] box_min_x;
   logic signed [31:0] box_min_y;
   logic signed [31:0] box_min_z;
   logic [30:0] box_size_x;
   logic [30:0] box_size_y;
   logic [30:0] box_size_z;
   logic [6:0]  vertex_count;
   logic        hull_empty;
   logic        store_full;
   modport source(output valid, support_x, support_y, support_z, box_min_x, box_min_y,
      box_min_z, box_size_x, box_size_y, box_size_z, vertex_count, hull_empty,
      store_full, input ready);
   modport sink(input valid, support_x, support_y, support_z, box_min_x, box_min_y,
      box_min_z, box_size_x, box_size_y, box_size_z, vertex_count, hull_empty,
      store_full, output ready);
endinterface
`default_nettype wire

>>> rtl/convex_hull_support_point.sv
`default_nettype none
// Sequence: clear/append/load, and a query on an empty hull, go to the done state and respond.
//   A query on a nonempty hull rotates the direction into the local frame, fetches the first read,
//   scans every vertex, transforms the winner back with the origin added, then responds.
// Throughput: one request at a time; the next is taken once the result has been consumed.
// Reset (synchronous): empty store, zero box, identity basis, zero origin.
module convex_hull_support_point #(
   parameter int unsigned MAX_VERTICES = chsp_pkg::DefMaxVertices,
   parameter int unsigned FRAC_BITS    = chsp_pkg::DefFracBits
) (
   input wire         clock,
   input wire         reset,
   chsp_req_if.sink   req,
   chsp_rsp_if.source rsp
);
   import chsp_pkg::*;
   localparam int unsigned CntW = $clog2(MAX_VERTICES+1);
   localparam logic signed [ValueWidth-1:0] One = ValueWidth'(1) << FRAC_BITS;

   state_type state_ff, state_in;
   logic [CntW-1:0] total_ff, total_in;
   logic signed [ValueWidth-1:0] lo_ff [3], hi_ff [3];
   logic signed [ValueWidth-1:0] basis_ff [9];
   logic signed [ValueWidth-1:0] org_ff [3];
   logic signed [ValueWidth-1:0] dir_ff [3];   // request vector
   logic signed [ValueWidth-1:0] ld_ff [3];    // local direction
   logic signed [ValueWidth-1:0] vtx_ff [3];   // winning vertex
   logic signed [ValueWidth-1:0] sup_ff [3];
   logic signed [AccWidth-1:0]   best_ff;
   logic [CntW-1:0] idx_ff;                    // vertex index
   logic [2:0] step_ff;                        // MAC slot 0..4
   logic [1:0] comp_ff;                        // output component
   logic empty_ff, full_ff, rsp_valid_ff;

   logic signed [ValueWidth-1:0] op_a, op_b;
   mac_ctrl_type mac_ctrl;
   logic signed [AccWidth-1:0] acc;
   logic [3*ValueWidth-1:0] rd_data;
   logic [CntW-1:0] rd_addr;
   logic wr_en;
   logic signed [AccWidth-1:0] acc_floor;

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   wire accept = req.valid && req.ready;
   assign wr_en = accept && (kind_type'(req.kind) == KIND_APPEND) &&
                  (total_ff < CntW'(MAX_VERTICES));

   chsp_store #(.MAX_VERTICES(MAX_VERTICES)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(total_ff),
      .wr_data({req.value_z, req.value_y, req.value_x}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   chsp_mac u_mac (.clock(clock), .ctrl(mac_ctrl), .op_a(op_a), .op_b(op_b), .acc(acc));

   assign acc_floor = acc >>> FRAC_BITS;
   // read data is registered: address the next vertex at step 4 so its data is there at step 0
   assign rd_addr = (state_ff == ST_SCAN && step_ff == 3'd4) ? idx_ff + CntW'(1) : idx_ff;

   // Slot schedule per component or vertex: step 0..2 issue products,
   // step 1..3 accumulate, step 4 reads the sum. Accumulator cleared at step 0.
   always_comb begin
      op_a = '0;
      op_b = '0;
      mac_ctrl.clear = (step_ff == 3'd0);
      mac_ctrl.accumulate = (step_ff >= 3'd1) && (step_ff <= 3'd3);
      unique case (state_ff)
         ST_ROT: begin
            // ld[c] = sum_i basis[i][c] * dir[i]
            if (step_ff <= 3'd2) begin
               op_a = basis_ff[{1'b0, step_ff} * 4'd3 + {2'b0, comp_ff}];
               op_b = dir_ff[step_ff[1:0]];
            end
         end
         ST_SCAN: begin
            if (step_ff <= 3'd2) begin
               op_a = rd_data[step_ff[1:0]*ValueWidth +: ValueWidth];
               op_b = ld_ff[step_ff[1:0]];
            end
         end
         ST_XFORM: begin
            if (step_ff <= 3'd2) begin
               op_a = basis_ff[{2'b0, comp_ff} * 4'd3 + {1'b0, step_ff}];
               op_b = vtx_ff[step_ff[1:0]];
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:
            if (accept) begin
               if (kind_type'(req.kind) == KIND_QUERY && total_ff != '0) state_in = ST_ROT;
               else state_in = ST_DONE;
            end
         ST_ROT:
            if (step_ff == 3'd4 && comp_ff == 2'd2) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_SCAN;
         ST_SCAN:
            if (step_ff == 3'd4 && idx_ff == total_ff - CntW'(1)) state_in = ST_XFORM;
         ST_XFORM:
            if (step_ff == 3'd4 && comp_ff == 2'd2) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      total_in = total_ff;
      if (accept) begin
         if (kind_type'(req.kind) == KIND_CLEAR) total_in = '0;
         else if (wr_en) total_in = total_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         comp_ff <= '0;
         idx_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            lo_ff[k] <= '0;
            hi_ff[k] <= '0;
            org_ff[k] <= '0;
         end
         for (int k = 0; k < 9; k++) basis_ff[k] <= (k % 4 == 0) ? One : '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         if (accept) begin
            step_ff <= '0;
            comp_ff <= '0;
            idx_ff <= '0;
            empty_ff <= 1'b0;
            full_ff <= 1'b0;
            for (int k = 0; k < 3; k++) sup_ff[k] <= '0;
            dir_ff[0] <= req.value_x;
            dir_ff[1] <= req.value_y;
            dir_ff[2] <= req.value_z;
            unique case (kind_type'(req.kind))
               KIND_CLEAR:
                  for (int k = 0; k < 3; k++) begin
                     lo_ff[k] <= '0;
                     hi_ff[k] <= '0;
                  end
               KIND_APPEND:
                  if (wr_en) begin
                     if (req.value_x < lo_ff[0] || total_ff == '0) lo_ff[0] <= req.value_x;
                     if (req.value_y < lo_ff[1] || total_ff == '0) lo_ff[1] <= req.value_y;
                     if (req.value_z < lo_ff[2] || total_ff == '0) lo_ff[2] <= req.value_z;
                     if (req.value_x > hi_ff[0] || total_ff == '0) hi_ff[0] <= req.value_x;
                     if (req.value_y > hi_ff[1] || total_ff == '0) hi_ff[1] <= req.value_y;
                     if (req.value_z > hi_ff[2] || total_ff == '0) hi_ff[2] <= req.value_z;
                  end else full_ff <= 1'b1;
               KIND_LOAD:
                  if (req.row != 2'd3) begin
                     basis_ff[{2'b0, req.row} * 4'd3]        <= req.value_x;
                     basis_ff[{2'b0, req.row} * 4'd3 + 4'd1] <= req.value_y;
                     basis_ff[{2'b0, req.row} * 4'd3 + 4'd2] <= req.value_z;
                     org_ff[req.row]                         <= req.value_w;
                  end
               KIND_QUERY:
                  if (total_ff == '0) empty_ff <= 1'b1;
               default: ;
            endcase
         end else begin
            unique case (state_ff)
               ST_ROT: begin
                  step_ff <= (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
                  if (step_ff == 3'd4) begin
                     ld_ff[comp_ff] <= sat32(acc_floor);
                     comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
                  end
               end
               ST_FETCH: step_ff <= '0;
               ST_SCAN: begin
                  step_ff <= (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
                  if (step_ff == 3'd4) begin
                     // exact compare; first strictly greater wins
                     if (idx_ff == '0 || acc > best_ff) begin
                        best_ff <= acc;
                        vtx_ff[0] <= rd_data[0 +: ValueWidth];
                        vtx_ff[1] <= rd_data[ValueWidth +: ValueWidth];
                        vtx_ff[2] <= rd_data[2*ValueWidth +: ValueWidth];
                     end
                     idx_ff <= idx_ff + CntW'(1);
                  end
               end
               ST_XFORM: begin
                  step_ff <= (step_ff == 3'd4) ? 3'd0 : step_ff + 3'd1;
                  if (step_ff == 3'd4) begin
                     sup_ff[comp_ff] <= sat32(acc_floor + AccWidth'(org_ff[comp_ff]));
                     comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   function automatic logic [SizeWidth-1:0] box_size(
      input logic signed [ValueWidth-1:0] hi,
      input logic signed [ValueWidth-1:0] lo
   );
      logic signed [ValueWidth:0] d;
      begin
         d = {hi[ValueWidth-1], hi} - {lo[ValueWidth-1], lo};
         if (d[ValueWidth]) box_size = '0;
         else if (d[ValueWidth-1]) box_size = '1;
         else box_size = d[SizeWidth-1:0];
      end
   endfunction

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.support_x    = sup_ff[0];
   assign rsp.support_y    = sup_ff[1];
   assign rsp.support_z    = sup_ff[2];
   assign rsp.box_min_x    = lo_ff[0];
   assign rsp.box_min_y    = lo_ff[1];
   assign rsp.box_min_z    = lo_ff[2];
   assign rsp.box_size_x   = box_size(hi_ff[0], lo_ff[0]);
   assign rsp.box_size_y   = box_size(hi_ff[1], lo_ff[1]);
   assign rsp.box_size_z   = box_size(hi_ff[2], lo_ff[2]);
   assign rsp.vertex_count = CountWidth'(total_ff);
   assign rsp.hull_empty   = empty_ff;
   assign rsp.store_full   = full_ff;
endmodule
`default_nettype wire

>>> rtl/chsp_mac.sv
`default_nettype none
// Shared multiply-accumulate: one 32x32 product per cycle, registered, then summed.
module chsp_mac (
   input  wire                                      clock,
   input  chsp_pkg::mac_ctrl_type                   ctrl,
   input  wire logic signed [chsp_pkg::ValueWidth-1:0] op_a,
   input  wire logic signed [chsp_pkg::ValueWidth-1:0] op_b,
   output logic signed [chsp_pkg::AccWidth-1:0]     acc
);
   import chsp_pkg::*;
   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [AccWidth-1:0]  acc_ff;
   logic signed [AccWidth-1:0]  acc_in;
   // ctrl applies to the product registered in the previous cycle
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) acc_in = '0;
      else if (ctrl.accumulate) acc_in = acc_ff + AccWidth'(prod_ff);
   end
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
   end
   assign acc = acc_ff;
endmodule
`default_nettype wire

>>> rtl/chsp_store.sv
`default_nettype none
module chsp_store #(
   parameter int unsigned MAX_VERTICES = chsp_pkg::DefMaxVertices
) (
   input  wire                                       clock,
   input  wire                                       wr_en,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0]    wr_addr,
   input  wire logic [3*chsp_pkg::ValueWidth-1:0]    wr_data,
   input  wire logic [$clog2(MAX_VERTICES+1)-1:0]    rd_addr,
   output logic [3*chsp_pkg::ValueWidth-1:0]         rd_data
);
   import chsp_pkg::*;
   localparam int unsigned AddrWidth = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   logic [3*ValueWidth-1:0] mem [MAX_VERTICES];
   logic [3*ValueWidth-1:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[AddrWidth-1:0]] <= wr_data;
      rd_ff <= mem[rd_addr[AddrWidth-1:0]];
   end
   assign rd_data = rd_ff;
endmodule
`default_nettype wire
